// File: rtl/core/sapl_pkg.sv
// Package for the serial autobaud probe and lock controller.
// Holds the item codes, probe constants and the result type.
// No dependencies.
`default_nettype none

package sapl_pkg;

  localparam logic [1:0] OP_BYTE      = 2'd0;
  localparam logic [1:0] OP_POLL      = 2'd1;
  localparam logic [1:0] OP_POWER_ON  = 2'd2;
  localparam logic [1:0] OP_POWER_OFF = 2'd3;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_RMC  = 2'd2;

  localparam logic [0:0] CFG_PROBE_MS       = 1'd0;
  localparam logic [0:0] CFG_FIX_MAX_AGE_MS = 1'd1;

  localparam logic [15:0] PROBE_MS_RESET       = 16'd2000;
  localparam logic [15:0] FIX_MAX_AGE_MS_RESET = 16'd2000;

  localparam logic [3:0]  PROBE_LAST = 4'd11;
  localparam logic [15:0] BYTES_MAX  = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  baud_select;
    logic        pins_swapped;
    logic        locked;
    logic        has_fix;
    logic        new_sample;
    logic        report_valid;
    logic [2:0]  report_baud_select;
    logic        report_pins_swapped;
    logic [15:0] report_bytes;
  } sapl_result_t;

endpackage

`default_nettype wire

// File: rtl/core/sapl_core.sv
// State and update logic of the probe and lock controller, one item per cycle while step_i is high.
// Depends on sapl_pkg.
`default_nettype none

module sapl_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire logic [1:0]            opcode_i,
  input  wire logic [31:0]           now_ms_i,
  input  wire logic [1:0]            sentence_kind_i,
  input  wire logic                  fix_valid_i,
  input  wire logic [15:0]           probe_ms_i,
  input  wire logic [15:0]           fix_max_age_ms_i,
  output sapl_pkg::sapl_result_t     result_o
);
  import sapl_pkg::*;

  logic        powered_q, powered_d;
  logic        lock_q, lock_d;
  logic        ever_fixed_q, ever_fixed_d;
  logic [3:0]  probe_index_q, probe_index_d;
  logic [31:0] probe_start_q, probe_start_d;
  logic [31:0] last_sentence_q, last_sentence_d;
  logic [31:0] last_fix_q, last_fix_d;
  logic [15:0] window_bytes_q, window_bytes_d;

  logic [31:0] since_sentence;
  logic [31:0] since_probe;
  logic [31:0] since_fix;
  logic [18:0] silence_limit;
  logic        unlock;
  logic        expire;
  logic        fix_update;

  assign since_sentence = now_ms_i - last_sentence_q;
  assign since_probe    = now_ms_i - probe_start_q;
  assign since_fix      = now_ms_i - last_fix_q;
  assign silence_limit  = {1'b0, probe_ms_i, 2'b00} + {3'b000, probe_ms_i};

  always_comb begin
    powered_d       = powered_q;
    lock_d          = lock_q;
    ever_fixed_d    = ever_fixed_q;
    probe_index_d   = probe_index_q;
    probe_start_d   = probe_start_q;
    last_sentence_d = last_sentence_q;
    last_fix_d      = last_fix_q;
    window_bytes_d  = window_bytes_q;
    unlock          = 1'b0;
    expire          = 1'b0;
    fix_update      = 1'b0;
    result_o        = '0;

    unique case (opcode_i)
      OP_BYTE: begin
        if (powered_q) begin
          if (window_bytes_q != BYTES_MAX) begin
            window_bytes_d = window_bytes_q + 16'd1;
          end
          if (sentence_kind_i != KIND_NONE) begin
            last_sentence_d = now_ms_i;
            lock_d          = 1'b1;
            if (sentence_kind_i == KIND_RMC) begin
              result_o.new_sample = 1'b1;
              if (fix_valid_i) begin
                fix_update   = 1'b1;
                last_fix_d   = now_ms_i;
                ever_fixed_d = 1'b1;
              end
            end
          end
        end
      end
      OP_POLL: begin
        if (powered_q) begin
          unlock = lock_q && (since_sentence > {13'd0, silence_limit});
          // A fresh unlock restarts the window, so it only expires at once for a zero window.
          expire = unlock ? (probe_ms_i == 16'd0)
                          : (!lock_q && (since_probe >= {16'd0, probe_ms_i}));
          if (unlock) begin
            lock_d        = 1'b0;
            probe_start_d = now_ms_i;
          end
          if (expire) begin
            result_o.report_valid        = 1'b1;
            result_o.report_baud_select  = probe_index_q[3:1];
            result_o.report_pins_swapped = probe_index_q[0];
            result_o.report_bytes        = window_bytes_q;
            probe_index_d  = (probe_index_q >= PROBE_LAST) ? 4'd0 : probe_index_q + 4'd1;
            probe_start_d  = now_ms_i;
            window_bytes_d = 16'd0;
          end
        end
      end
      OP_POWER_ON: begin
        if (!powered_q) begin
          powered_d     = 1'b1;
          probe_start_d = now_ms_i;
        end
      end
      OP_POWER_OFF: begin
        powered_d = 1'b0;
      end
      default: begin
        powered_d = powered_q;
      end
    endcase

    result_o.baud_select  = probe_index_d[3:1];
    result_o.pins_swapped = probe_index_d[0];
    result_o.locked       = lock_d;
    result_o.has_fix      = powered_d && ever_fixed_d &&
                            (fix_update || (since_fix <= {16'd0, fix_max_age_ms_i}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      powered_q       <= 1'b0;
      lock_q          <= 1'b0;
      ever_fixed_q    <= 1'b0;
      probe_index_q   <= 4'd0;
      probe_start_q   <= 32'd0;
      last_sentence_q <= 32'd0;
      last_fix_q      <= 32'd0;
      window_bytes_q  <= 16'd0;
    end else if (step_i) begin
      powered_q       <= powered_d;
      lock_q          <= lock_d;
      ever_fixed_q    <= ever_fixed_d;
      probe_index_q   <= probe_index_d;
      probe_start_q   <= probe_start_d;
      last_sentence_q <= last_sentence_d;
      last_fix_q      <= last_fix_d;
      window_bytes_q  <= window_bytes_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/serial_autobaud_probe_lock.sv
// An accepted item passes the input register, then the result register, before its result shows.
// Throughput: one item per cycle unless the output is stalled; the state update for an item
// completes in the cycle it leaves the input register, so the next item sees it at once.
// Reset clears the valid flags and core state; both configuration registers return to 2000 ms.
// Top level of the probe and lock controller; depends on sapl_pkg and sapl_core.
`default_nettype none

module serial_autobaud_probe_lock (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic [1:0]  sentence_kind_i,
  input  wire logic        fix_valid_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       baud_select_o,
  output logic             pins_swapped_o,
  output logic             locked_o,
  output logic             has_fix_o,
  output logic             new_sample_o,
  output logic             report_valid_o,
  output logic [2:0]       report_baud_select_o,
  output logic             report_pins_swapped_o,
  output logic [15:0]      report_bytes_o
);
  import sapl_pkg::*;

  logic [15:0]  probe_ms_q;
  logic [15:0]  fix_max_age_ms_q;
  logic         s1_valid_q;
  logic [1:0]   s1_opcode_q;
  logic [31:0]  s1_now_q;
  logic [1:0]   s1_kind_q;
  logic         s1_fix_q;
  logic         s1_fire;
  logic         in_accept;
  logic         out_valid_q;
  sapl_result_t result_d;
  sapl_result_t result_q;

  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_ms_q       <= PROBE_MS_RESET;
      fix_max_age_ms_q <= FIX_MAX_AGE_MS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PROBE_MS:       probe_ms_q       <= cfg_data_i;
        CFG_FIX_MAX_AGE_MS: fix_max_age_ms_q <= cfg_data_i;
        default:            probe_ms_q       <= probe_ms_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= in_accept || (s1_valid_q && !s1_fire);
      out_valid_q <= s1_fire || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_opcode_q <= opcode_i;
      s1_now_q    <= now_ms_i;
      s1_kind_q   <= sentence_kind_i;
      s1_fix_q    <= fix_valid_i;
    end
    if (s1_fire) begin
      result_q <= result_d;
    end
  end

  sapl_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (s1_fire),
    .opcode_i         (s1_opcode_q),
    .now_ms_i         (s1_now_q),
    .sentence_kind_i  (s1_kind_q),
    .fix_valid_i      (s1_fix_q),
    .probe_ms_i       (probe_ms_q),
    .fix_max_age_ms_i (fix_max_age_ms_q),
    .result_o         (result_d)
  );

  assign out_valid_o           = out_valid_q;
  assign baud_select_o         = result_q.baud_select;
  assign pins_swapped_o        = result_q.pins_swapped;
  assign locked_o              = result_q.locked;
  assign has_fix_o             = result_q.has_fix;
  assign new_sample_o          = result_q.new_sample;
  assign report_valid_o        = result_q.report_valid;
  assign report_baud_select_o  = result_q.report_baud_select;
  assign report_pins_swapped_o = result_q.report_pins_swapped;
  assign report_bytes_o        = result_q.report_bytes;

endmodule

`default_nettype wire

// File: rtl/core/sapl_checker.sv
// Port-level checks for the probe and lock controller, bound to its top level.
// Depends only on the ports of serial_autobaud_probe_lock.
`default_nettype none

module sapl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  baud_select_o,
  input wire logic        locked_o,
  input wire logic        new_sample_o,
  input wire logic        report_valid_o,
  input wire logic [2:0]  report_baud_select_o,
  input wire logic        report_pins_swapped_o,
  input wire logic [15:0] report_bytes_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(report_bytes_o)
      && $stable(baud_select_o) && $stable(locked_o))
    else $error("stalled item changed");

  a_report_unlocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && report_valid_o |-> !locked_o)
    else $error("report while locked");

  a_report_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !report_valid_o |-> report_bytes_o == 16'd0
      && report_baud_select_o == 3'd0 && !report_pins_swapped_o)
    else $error("report fields not cleared");

  a_baud_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> baud_select_o <= 3'd5 && report_baud_select_o <= 3'd5)
    else $error("baud index out of range");

  a_sample_locks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && new_sample_o |-> locked_o && !report_valid_o)
    else $error("new sample without lock");

endmodule

bind serial_autobaud_probe_lock sapl_checker u_sapl_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .out_valid_o           (out_valid_o),
  .out_stall_i           (out_stall_i),
  .baud_select_o         (baud_select_o),
  .locked_o              (locked_o),
  .new_sample_o          (new_sample_o),
  .report_valid_o        (report_valid_o),
  .report_baud_select_o  (report_baud_select_o),
  .report_pins_swapped_o (report_pins_swapped_o),
  .report_bytes_o        (report_bytes_o)
);

`default_nettype wire
